FILE: rtl/core/dttm_pkg.sv
// ----------------------------------------------------------------------------
// dttm_pkg
// Shared types and constants for the deadline task timing monitor.
// ----------------------------------------------------------------------------
package dttm_pkg;

   localparam int TaskIdWidth = 22;
   localparam int CsrIdxWidth = 3;

   // configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_TASK_ID  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_DL_MODE  = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_BUDGET   = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_DEADLINE = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_PERIOD   = 3'd4;

   // controller -> datapath commands
   typedef struct packed {
      logic load;      // capture input beat, compute first-stage results
      logic div_init;  // start period division
      logic div_step;  // one restoring division step
      logic finish;    // commit ready time and cycle count
   } dttm_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic need_div;  // ready time behind stop in deadline mode
      logic div_last;  // final division step in progress
   } dttm_sts_type;

endpackage

FILE: rtl/core/dttm_ctrl.sv
// ----------------------------------------------------------------------------
// dttm_ctrl
// Sequencer: accept beat, evaluate, iterate the divider, present result.
// ----------------------------------------------------------------------------
module dttm_ctrl
   import dttm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  dttm_sts_type sts,
   output dttm_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EVAL = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_FIN  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (sts.need_div) begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // a beat is only taken while idle
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_EVAL))
      else $error("accept did not enter eval");
   // result held while stalled
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");
   // divider steps never run outside the divide state
   a_step_state: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (state_ff == ST_DIV))
      else $error("divide step out of state");

endmodule

FILE: rtl/core/dttm_dp.sv
// ----------------------------------------------------------------------------
// dttm_dp
// Datapath: run time, statistics, ready time, restoring period divider.
// ----------------------------------------------------------------------------
module dttm_dp
   import dttm_pkg::*;
#(
   parameter int TIME_WIDTH  = 64,
   parameter int COUNT_WIDTH = 32
)(
   input  logic                   clock,
   input  logic                   reset,
   input  dttm_cmd_type           cmd,
   output dttm_sts_type           sts,
   input  logic                   csr_valid,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [TIME_WIDTH-1:0]  csr_data,
   input  logic [TaskIdWidth-1:0] req_task_id,
   input  logic [TIME_WIDTH-1:0]  req_start_time,
   input  logic [TIME_WIDTH-1:0]  req_stop_time,
   output logic                   rsp_accepted,
   output logic [TIME_WIDTH-1:0]  rsp_run_time,
   output logic [TIME_WIDTH-1:0]  rsp_latency,
   output logic                   rsp_deadline_missed,
   output logic                   rsp_runtime_overrun,
   output logic [TIME_WIDTH-1:0]  rsp_worst_run_time,
   output logic [TIME_WIDTH-1:0]  rsp_best_run_time,
   output logic [TIME_WIDTH-1:0]  rsp_max_latency_seen,
   output logic [COUNT_WIDTH-1:0] rsp_deadline_miss_total,
   output logic [COUNT_WIDTH-1:0] rsp_overrun_total,
   output logic [COUNT_WIDTH-1:0] rsp_depleted_total,
   output logic [COUNT_WIDTH-1:0] rsp_cycle_total
);

   localparam int SW = $clog2(TIME_WIDTH + 1);
   localparam logic [TIME_WIDTH-1:0]  TMAX = '1;
   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

   // configuration registers
   logic [TaskIdWidth-1:0] task_id_ff;
   logic                   mode_ff;
   logic [TIME_WIDTH-1:0]  budget_ff, deadline_ff, period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         task_id_ff  <= '0;
         mode_ff     <= 1'b0;
         budget_ff   <= '0;
         deadline_ff <= '0;
         period_ff   <= {{(TIME_WIDTH-1){1'b0}}, 1'b1};
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TASK_ID:  task_id_ff  <= csr_data[TaskIdWidth-1:0];
            CSR_DL_MODE:  mode_ff     <= csr_data[0];
            CSR_BUDGET:   budget_ff   <= csr_data;
            CSR_DEADLINE: deadline_ff <= csr_data;
            CSR_PERIOD:   period_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   logic [TIME_WIDTH-1:0] per;
   assign per = (period_ff == '0) ? {{(TIME_WIDTH-1){1'b0}}, 1'b1} : period_ff;

   // captured beat
   logic [TaskIdWidth-1:0] id_ff;
   logic [TIME_WIDTH-1:0]  start_ff, stop_ff;

   // statistic state
   logic [TIME_WIDTH-1:0]  ready_ff, ready_in, worst_ff, best_ff, maxlat_ff;
   logic [COUNT_WIDTH-1:0] miss_ff, over_ff, depl_ff, cyc_ff;

   // per-item results
   logic                  acc_ff, missed_ff, overf_ff;
   logic [TIME_WIDTH-1:0] rt_ff, lat_ff;

   // divider
   logic [TIME_WIDTH-1:0] quo_ff, rem_ff, dm1_ff;
   logic [SW-1:0]         cnt_ff;

   // evaluation combinational terms, from captured beat
   logic                  acc, mode_on;
   logic [TIME_WIDTH-1:0] rt, rdy0, rdy1, lat, since;
   assign acc     = (id_ff == task_id_ff);
   assign mode_on = acc && mode_ff;
   assign rt      = stop_ff - start_ff;
   assign rdy0    = (ready_ff == '0) ? start_ff : ready_ff;
   assign rdy1    = (start_ff < rdy0) ? start_ff : rdy0;
   assign lat     = start_ff - rdy1;
   assign since   = stop_ff - rdy1;

   function automatic logic [COUNT_WIDTH-1:0] inc_sat(input logic [COUNT_WIDTH-1:0] c);
      inc_sat = (c == CMAX) ? c : c + 1'b1;
   endfunction

   logic eval_ff;
   always_ff @(posedge clock) begin
      if (reset) eval_ff <= 1'b0;
      else       eval_ff <= cmd.load;
   end

   assign sts.need_div = mode_on && (rdy1 < stop_ff);
   assign sts.div_last = (cnt_ff == SW'(1));

   // restoring division step
   logic [TIME_WIDTH:0]   trial;
   logic [TIME_WIDTH-1:0] rem_sh;
   assign rem_sh = {rem_ff[TIME_WIDTH-2:0], quo_ff[TIME_WIDTH-1]};
   assign trial  = {rem_ff[TIME_WIDTH-1], rem_sh} - {1'b0, per};

   // commit terms
   logic [TIME_WIDTH-1:0]  base, nper, step_rem;
   logic [TIME_WIDTH:0]    sum;
   logic [COUNT_WIDTH-1:0] nper_c;
   logic                   nper_big;
   assign step_rem = rem_ff;
   assign base     = ready_ff + (dm1_ff - step_rem);
   assign sum      = {1'b0, base} + {1'b0, per};
   assign nper     = quo_ff + 1'b1;
   assign nper_big = (nper == '0) ||
                     ((TIME_WIDTH > COUNT_WIDTH) &&
                      ((nper >> COUNT_WIDTH) != '0));
   assign nper_c   = COUNT_WIDTH'(nper);

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff  <= '0;
         worst_ff  <= '0;
         best_ff   <= TMAX;
         maxlat_ff <= '0;
         miss_ff   <= '0;
         over_ff   <= '0;
         depl_ff   <= '0;
         cyc_ff    <= '0;
         cnt_ff    <= '0;
      end else begin
         if (eval_ff && acc) begin
            if (rt > worst_ff)     worst_ff <= rt;
            else if (rt < best_ff) best_ff  <= rt;
            if (mode_ff) begin
               ready_ff <= rdy1;
               if (lat > maxlat_ff) maxlat_ff <= lat;
               if (since > deadline_ff) miss_ff <= inc_sat(miss_ff);
               if (rt > budget_ff) begin
                  over_ff <= inc_sat(over_ff);
                  if (rt > per) depl_ff <= inc_sat(depl_ff);
               end
            end
         end
         if (cmd.div_init) cnt_ff <= SW'(TIME_WIDTH);
         else if (cmd.div_step) cnt_ff <= cnt_ff - 1'b1;
         if (cmd.finish) begin
            ready_ff <= ready_in;
            if (nper_big || (COUNT_WIDTH'(CMAX - cyc_ff) <= nper_c) || cyc_ff == CMAX)
               cyc_ff <= CMAX;
            else
               cyc_ff <= cyc_ff + nper_c;
         end
      end
   end

   assign ready_in = sum[TIME_WIDTH] ? TMAX : sum[TIME_WIDTH-1:0];

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff    <= req_task_id;
         start_ff <= req_start_time;
         stop_ff  <= req_stop_time;
      end
      if (eval_ff) begin
         acc_ff    <= acc;
         rt_ff     <= acc ? rt : '0;
         lat_ff    <= mode_on ? lat : '0;
         missed_ff <= mode_on && (since > deadline_ff);
         overf_ff  <= mode_on && (rt > budget_ff);
      end
      if (cmd.div_init) begin
         dm1_ff <= stop_ff - rdy1 - 1'b1;
         quo_ff <= stop_ff - rdy1 - 1'b1;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         if (!trial[TIME_WIDTH]) begin
            rem_ff <= trial[TIME_WIDTH-1:0];
            quo_ff <= {quo_ff[TIME_WIDTH-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[TIME_WIDTH-2:0], 1'b0};
         end
      end
   end

   assign rsp_accepted            = acc_ff;
   assign rsp_run_time            = rt_ff;
   assign rsp_latency             = lat_ff;
   assign rsp_deadline_missed     = missed_ff;
   assign rsp_runtime_overrun     = overf_ff;
   assign rsp_worst_run_time      = worst_ff;
   assign rsp_best_run_time       = best_ff;
   assign rsp_max_latency_seen    = maxlat_ff;
   assign rsp_deadline_miss_total = miss_ff;
   assign rsp_overrun_total       = over_ff;
   assign rsp_depleted_total      = depl_ff;
   assign rsp_cycle_total         = cyc_ff;

   // remainder stays below the divisor once a step has run
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.div_step) |-> (rem_ff < per))
      else $error("divider remainder out of range");
   // worst never shrinks
   a_worst_mono: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (worst_ff >= $past(worst_ff)))
      else $error("worst run time decreased");
   // miss counter never wraps
   a_miss_mono: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (miss_ff >= $past(miss_ff)))
      else $error("miss count wrapped");

endmodule

FILE: rtl/core/deadline_task_timing_monitor.sv
// Result path: the result beat comes after the eval state outside deadline
// mode or when no advance is due, and after eval, the divide states and
// finish when the ready time is advanced; the one-bit-per-cycle restoring
// divider forms the period count. Items are handled one at a time; the next
// beat is taken in the cycle after the result beat. Reset: synchronous, clears
// settings (period = 1), statistics and ready time; best = all ones.
// ----------------------------------------------------------------------------
// deadline_task_timing_monitor
// Top level: periodic task run time, latency and deadline statistics.
// ----------------------------------------------------------------------------
module deadline_task_timing_monitor
   import dttm_pkg::*;
#(
   parameter int TIME_WIDTH  = 64,
   parameter int COUNT_WIDTH = 32
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [TIME_WIDTH-1:0]  csr_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [TaskIdWidth-1:0] req_task_id,
   input  logic [TIME_WIDTH-1:0]  req_start_time,
   input  logic [TIME_WIDTH-1:0]  req_stop_time,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_accepted,
   output logic [TIME_WIDTH-1:0]  rsp_run_time,
   output logic [TIME_WIDTH-1:0]  rsp_latency,
   output logic                   rsp_deadline_missed,
   output logic                   rsp_runtime_overrun,
   output logic [TIME_WIDTH-1:0]  rsp_worst_run_time,
   output logic [TIME_WIDTH-1:0]  rsp_best_run_time,
   output logic [TIME_WIDTH-1:0]  rsp_max_latency_seen,
   output logic [COUNT_WIDTH-1:0] rsp_deadline_miss_total,
   output logic [COUNT_WIDTH-1:0] rsp_overrun_total,
   output logic [COUNT_WIDTH-1:0] rsp_depleted_total,
   output logic [COUNT_WIDTH-1:0] rsp_cycle_total
);

   dttm_cmd_type cmd;
   dttm_sts_type sts;

   assign csr_ready = 1'b1;

   dttm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   dttm_dp #(.TIME_WIDTH(TIME_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .sts                     (sts),
      .csr_valid               (csr_valid),
      .csr_index               (csr_index),
      .csr_data                (csr_data),
      .req_task_id             (req_task_id),
      .req_start_time          (req_start_time),
      .req_stop_time           (req_stop_time),
      .rsp_accepted            (rsp_accepted),
      .rsp_run_time            (rsp_run_time),
      .rsp_latency             (rsp_latency),
      .rsp_deadline_missed     (rsp_deadline_missed),
      .rsp_runtime_overrun     (rsp_runtime_overrun),
      .rsp_worst_run_time      (rsp_worst_run_time),
      .rsp_best_run_time       (rsp_best_run_time),
      .rsp_max_latency_seen    (rsp_max_latency_seen),
      .rsp_deadline_miss_total (rsp_deadline_miss_total),
      .rsp_overrun_total       (rsp_overrun_total),
      .rsp_depleted_total      (rsp_depleted_total),
      .rsp_cycle_total         (rsp_cycle_total)
   );

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the deadline task timing monitor: writes several
// register settings, sends directed and random timestamp pairs with random
// stalls on both sides and checks every result beat against a predictor.
// ----------------------------------------------------------------------------
module testbench;
   import dttm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          LatWait   = 80;
   localparam int          CycLimit  = 2000000;
   localparam bit [63:0]   TimeMax   = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam bit [63:0]   CountMax  = 64'h0000_0000_FFFF_FFFF;
   localparam bit [21:0]   IdMax     = 22'h3F_FFFF;

   typedef struct {
      bit [21:0] id;
      bit [63:0] start;
      bit [63:0] stop;
   } job_type;

   typedef struct {
      bit        accepted;
      bit [63:0] run_time;
      bit [63:0] latency;
      bit        missed;
      bit        overrun;
      bit [63:0] worst;
      bit [63:0] best;
      bit [63:0] max_lat;
      bit [31:0] miss_tot;
      bit [31:0] over_tot;
      bit [31:0] depl_tot;
      bit [31:0] cyc_tot;
   } stats_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [63:0]            csr_data;
   logic                   req_valid;
   logic                   req_stall;
   logic [TaskIdWidth-1:0] req_task_id;
   logic [63:0]            req_start_time;
   logic [63:0]            req_stop_time;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_accepted;
   logic [63:0]            rsp_run_time;
   logic [63:0]            rsp_latency;
   logic                   rsp_deadline_missed;
   logic                   rsp_runtime_overrun;
   logic [63:0]            rsp_worst_run_time;
   logic [63:0]            rsp_best_run_time;
   logic [63:0]            rsp_max_latency_seen;
   logic [31:0]            rsp_deadline_miss_total;
   logic [31:0]            rsp_overrun_total;
   logic [31:0]            rsp_depleted_total;
   logic [31:0]            rsp_cycle_total;

   deadline_task_timing_monitor i_dut (.*);

   // predictor copy of registers and state
   bit [21:0] cfg_id;
   bit        cfg_dl;
   bit [63:0] cfg_budget, cfg_deadline, cfg_period;
   bit [63:0] ready_t, worst_t, best_t, lat_max;
   bit [63:0] misses, overruns, depletions, cycles;

   job_type   pending_jobs[$];
   stats_type expected_stats[$];
   int        fails;
   int        cyc_count;
   bit        idle_en;
   int        req_gap, rsp_gap;

   function automatic bit [63:0] sat_inc(bit [63:0] c, bit [63:0] n);
      if (c >= CountMax || n >= CountMax - c) return CountMax;
      return c + n;
   endfunction

   // advance the timing statistics by one job and return the result beat
   function automatic stats_type track_job(job_type j);
      stats_type r;
      bit [63:0] per, dm1, base, nper;
      r = '{default: '0};
      r.accepted = (j.id == cfg_id);
      if (r.accepted) begin
         r.run_time = j.stop - j.start;
         if (r.run_time > worst_t) worst_t = r.run_time;
         else if (r.run_time < best_t) best_t = r.run_time;
         if (cfg_dl) begin
            per = (cfg_period == 0) ? 64'd1 : cfg_period;
            if (ready_t == 0) ready_t = j.start;
            if (j.start < ready_t) ready_t = j.start;
            r.latency = j.start - ready_t;
            if (r.latency > lat_max) lat_max = r.latency;
            if (j.stop - ready_t > cfg_deadline) begin
               r.missed = 1'b1;
               misses   = sat_inc(misses, 64'd1);
            end
            if (r.run_time > cfg_budget) begin
               r.overrun = 1'b1;
               overruns  = sat_inc(overruns, 64'd1);
               if (r.run_time > per) depletions = sat_inc(depletions, 64'd1);
            end
            // step ready time by whole periods past the stop
            if (ready_t < j.stop) begin
               dm1  = j.stop - ready_t - 64'd1;
               base = ready_t + (dm1 - dm1 % per);
               nper = dm1 / per + 64'd1;
               ready_t = (per > TimeMax - base) ? TimeMax : base + per;
               if (nper == 0) nper = TimeMax;
               cycles = sat_inc(cycles, nper);
            end
         end
      end
      r.worst    = worst_t;
      r.best     = best_t;
      r.max_lat  = lat_max;
      r.miss_tot = misses[31:0];
      r.over_tot = overruns[31:0];
      r.depl_tot = depletions[31:0];
      r.cyc_tot  = cycles[31:0];
      return r;
   endfunction

   // clock
   initial begin
      clock = 1'b0;
   end
   always #5 clock = ~clock;

   // request driver: payload holds while stalled, random gaps between beats
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_stats.push_back(track_job(pending_jobs.pop_front()));
         end
         if (!(req_valid && req_stall)) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_jobs.size() > 0) begin
               if (idle_en && $urandom_range(0, 7) == 0) begin
                  req_gap = $urandom_range(0, 14);
                  req_valid <= 1'b0;
               end else begin
                  req_valid      <= 1'b1;
                  req_task_id    <= pending_jobs[0].id;
                  req_start_time <= pending_jobs[0].start;
                  req_stop_time  <= pending_jobs[0].stop;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_gap = 0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_stall <= 1'b1;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
         rsp_gap = $urandom_range(0, 14);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         fails++;
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      stats_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_stats.size() == 0) begin
            $error("result beat with nothing expected");
            fails++;
         end else begin
            e = expected_stats.pop_front();
            check_field("accepted", 64'(e.accepted), 64'(rsp_accepted));
            check_field("run_time", e.run_time, rsp_run_time);
            check_field("latency", e.latency, rsp_latency);
            check_field("deadline_missed", 64'(e.missed), 64'(rsp_deadline_missed));
            check_field("runtime_overrun", 64'(e.overrun), 64'(rsp_runtime_overrun));
            check_field("worst_run_time", e.worst, rsp_worst_run_time);
            check_field("best_run_time", e.best, rsp_best_run_time);
            check_field("max_latency_seen", e.max_lat, rsp_max_latency_seen);
            check_field("deadline_miss_total", 64'(e.miss_tot),
                        64'(rsp_deadline_miss_total));
            check_field("overrun_total", 64'(e.over_tot), 64'(rsp_overrun_total));
            check_field("depleted_total", 64'(e.depl_tot), 64'(rsp_depleted_total));
            check_field("cycle_total", 64'(e.cyc_tot), 64'(rsp_cycle_total));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cyc_count++;
      if (cyc_count > CycLimit) begin
         $display("FAIL deadline_task_timing_monitor");
         $finish;
      end
   end

   task automatic write_csr(logic [CsrIdxWidth-1:0] idx, bit [63:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_TASK_ID:  cfg_id       = val[21:0];
         CSR_DL_MODE:  cfg_dl       = val[0];
         CSR_BUDGET:   cfg_budget   = val;
         CSR_DEADLINE: cfg_deadline = val;
         CSR_PERIOD:   cfg_period   = val;
         default: ;
      endcase
   endtask

   task automatic setup(bit [21:0] id, bit dl, bit [63:0] bud, bit [63:0] dln,
                        bit [63:0] per);
      write_csr(CSR_TASK_ID, 64'(id));
      write_csr(CSR_DL_MODE, 64'(dl));
      write_csr(CSR_BUDGET, bud);
      write_csr(CSR_DEADLINE, dln);
      write_csr(CSR_PERIOD, per);
   endtask

   // wait for every beat to come back, then let the block settle
   task automatic drain();
      while (pending_jobs.size() > 0 || expected_stats.size() > 0 || req_valid)
         @(posedge clock);
      repeat (LatWait) @(posedge clock);
   endtask

   task automatic add_job(bit [21:0] id, bit [63:0] s, bit [63:0] p);
      @(negedge clock);
      pending_jobs.push_back('{id: id, start: s, stop: p});
   endtask

   // mostly periodic job traces for the configured task, plus noise
   task automatic random_jobs(int n);
      bit [63:0] t, s, rt;
      int        span, sel;
      t    = 64'($urandom_range(1, 1000000));
      span = (cfg_period > 100000) ? 100000 : int'(cfg_period);
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 19);
         if (sel < 15) begin
            if ($urandom_range(0, 5) == 0) s = t - 64'($urandom_range(1, span));
            else s = t + 64'($urandom_range(0, span / 4));
            rt = 64'($urandom_range(0, 2 * span));
            add_job(cfg_id, s, s + rt);
            t += cfg_period * ($urandom_range(0, 9) == 0 ? 64'd2 : 64'd1);
         end else if (sel < 18) begin
            add_job(cfg_id, {$urandom, $urandom}, {$urandom, $urandom});
         end else begin
            add_job(22'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
         end
      end
   endtask

   // stimulus
   initial begin
      bit [63:0] per, bud, dln;
      reset     <= 1'b1;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      req_task_id    <= '0;
      req_start_time <= '0;
      req_stop_time  <= '0;
      cfg_id = 0; cfg_dl = 0; cfg_budget = 0; cfg_deadline = 0; cfg_period = 1;
      ready_t = 0; worst_t = 0; best_t = TimeMax; lat_max = 0;
      misses = 0; overruns = 0; depletions = 0; cycles = 0;
      fails = 0; cyc_count = 0; idle_en = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, field extremes, wrap, rejects
      add_job(22'd0, 64'd0, 64'd0);
      add_job(22'd0, TimeMax, TimeMax);
      add_job(22'd0, TimeMax, 64'd0);
      add_job(22'd0, 64'd0, TimeMax);
      add_job(IdMax, 64'd5, 64'd9);
      add_job(22'd1, 64'd5, 64'd9);
      drain();

      // directed: deadline checks
      setup(IdMax, 1'b1, 64'd100, 64'd150, 64'd1000);
      add_job(IdMax, 64'd0, 64'd40);          // start at zero, ready steps to one period
      add_job(IdMax, 64'd1000, 64'd1050);     // on time
      add_job(IdMax, 64'd2000, 64'd2200);     // miss and overrun
      add_job(IdMax, 64'd2500, 64'd2550);     // early start
      add_job(IdMax, 64'd4000, 64'd6500);     // depletion
      add_job(IdMax, 64'd10000, 64'd9000);    // stop before start
      add_job(22'd3, 64'd11000, 64'd11010);   // reject in deadline mode
      add_job(IdMax, 64'hFFFF_FFFF_FFFF_FF00, TimeMax - 1); // ready saturates
      drain();
      setup(IdMax, 1'b1, TimeMax, TimeMax, 64'd1);
      add_job(IdMax, 64'd5, TimeMax);         // huge period count saturates
      add_job(IdMax, 64'd7, 64'd8);
      drain();
      setup(22'd0, 1'b1, 64'd0, 64'd0, TimeMax);
      add_job(22'd0, 64'd100, 64'd200);
      add_job(22'd0, 64'd300, TimeMax);
      drain();

      // random phases with varied settings
      for (int ph = 0; ph < 8; ph++) begin
         case ($urandom_range(0, 5))
            0:       per = 64'd1;
            1:       per = TimeMax;
            default: per = 64'($urandom_range(50, 5000));
         endcase
         case ($urandom_range(0, 3))
            0:       bud = 64'd0;
            1:       bud = TimeMax;
            default: bud = per / 2;
         endcase
         case ($urandom_range(0, 3))
            0:       dln = 64'd0;
            1:       dln = TimeMax;
            default: dln = per - per / 4;
         endcase
         setup(22'($urandom), $urandom_range(0, 3) != 0, bud, dln, per);
         if (ph == 7) idle_en = 1'b0;
         random_jobs(55);
         if (ph == 3) begin
            // sender holds off until everything is back
            while (pending_jobs.size() > 0 || expected_stats.size() > 0)
               @(posedge clock);
         end
         random_jobs(55);
         drain();
      end

      if (fails == 0) begin
         $display("PASS deadline_task_timing_monitor");
      end else begin
         $display("FAIL deadline_task_timing_monitor");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/dttm_pkg.sv
rtl/core/dttm_ctrl.sv
rtl/core/dttm_dp.sv
rtl/core/deadline_task_timing_monitor.sv
bench/testbench.sv
